### rtl/core/acav_pkg.sv
// acav_pkg: shared constants and helpers for the adc code to ascii voltage block
// depends on nothing; imported by the core and its checker
`default_nettype none

package acav_pkg;

    localparam int FRACTION_DIGITS_DEF = 7;
    localparam int FULL_SCALE_CODE     = 255;
    localparam int FULL_SCALE_VOLTS    = 5;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_DOT  = 8'h2E;
    localparam logic [7:0] ASCII_NL   = 8'h0A;

    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

### rtl/core/adc_code_to_ascii_voltage.sv
// adc_code_to_ascii_voltage: scales an 8-bit code to volts and sends it as ascii text
// depends on acav_pkg; scaling, digit extraction and character output in one pipeline
// the code is captured, multiplied, reduced to the reading and split digit by digit;
// then the output registers send the characters on consecutive cycles, newline last
// busy holds off new samples and counts down after each transaction, so that the one
// character per cycle outputs of successive readings do not overlap
// reset: synchronous, active low, clears valid bits, the spacing counter and the strobe
`default_nettype none

module adc_code_to_ascii_voltage import acav_pkg::*; #(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [7:0] i_adc_code,
    output logic            busy,
    output logic            o_strobe,
    output logic      [7:0] o_character,
    output logic            o_last
);

    localparam int              NCHAR = FRACTION_DIGITS + 3;
    localparam int              ND    = FRACTION_DIGITS + 1;
    localparam longint unsigned SCALE = pow10(FRACTION_DIGITS);
    localparam longint unsigned KFULL = SCALE * FULL_SCALE_VOLTS;
    localparam longint unsigned KQ    = KFULL / FULL_SCALE_CODE;
    localparam longint unsigned KR    = KFULL % FULL_SCALE_CODE;
    localparam int              RW    = $clog2(KFULL + 1);
    localparam int              VW    = RW + 1;
    localparam int              IW    = $clog2(NCHAR);

    // spacing counter
    logic          accept;
    logic [IW-1:0] r_gap;
    logic [IW-1:0] n_gap;

    assign busy   = (r_gap != '0);
    assign accept = start && !busy;

    always_comb begin
        if (accept) begin
            n_gap = IW'(NCHAR - 1);
        end else if (busy) begin
            n_gap = r_gap - IW'(1);
        end else begin
            n_gap = r_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else begin
            r_gap <= n_gap;
        end
    end

    // stage 1: capture code
    logic       r_s1_val;
    logic [7:0] r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_val <= 1'b0;
        end else begin
            r_s1_val <= accept;
        end
        r_code <= i_adc_code;
    end

    // stage 2: code * quotient and code * remainder of the full scale over 255
    logic          r_s2_val;
    logic [RW-1:0] r_p_hi;
    logic [15:0]   r_p_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_val <= 1'b0;
        end else begin
            r_s2_val <= r_s1_val;
        end
        r_p_hi <= RW'(64'(r_code) * KQ);
        r_p_lo <= {8'd0, r_code} * {8'd0, 8'(KR)};
    end

    // stage 3: exact floor of the low product over 255, then the reading
    logic [16:0]   n_q_lo;
    logic          r_val [0:ND];
    logic [RW-1:0] r_v   [0:ND-1];
    logic [ND-1:0][3:0] r_d [0:ND];

    assign n_q_lo = ({1'b0, r_p_lo} + 17'd1 + {9'd0, r_p_lo[15:8]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val[0] <= 1'b0;
        end else begin
            r_val[0] <= r_s2_val;
        end
        r_v[0] <= r_p_hi + RW'(n_q_lo[16:8]);
        r_d[0] <= '0;
    end

    // digit stages, most significant first
    for (genvar j = 0; j < ND; j++) begin : g_digit
        localparam longint unsigned PJ = pow10(FRACTION_DIGITS - j);

        logic [3:0]         n_stage_dig;
        logic [VW-1:0]      n_stage_sub;
        logic [ND-1:0][3:0] n_stage_d;

        always_comb begin
            n_stage_dig = '0;
            n_stage_sub = '0;
            for (int k = 1; k < 10; k++) begin
                if ({1'b0, r_v[j]} >= VW'(PJ * 64'(k))) begin
                    n_stage_dig = 4'(k);
                    n_stage_sub = VW'(PJ * 64'(k));
                end
            end
            n_stage_d    = r_d[j];
            n_stage_d[j] = n_stage_dig;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[j+1] <= 1'b0;
            end else begin
                r_val[j+1] <= r_val[j];
            end
            r_d[j+1] <= n_stage_d;
        end

        if (j < ND - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_v[j+1] <= RW'({1'b0, r_v[j]} - n_stage_sub);
            end
        end
    end

    // character output
    logic               r_active;
    logic               n_active;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      n_idx;
    logic [ND-1:0][3:0] r_dig;
    logic [ND-1:0][3:0] n_dig;
    logic               r_strobe;
    logic               n_strobe;
    logic               r_last;
    logic               n_last;
    logic [7:0]         r_char;
    logic [7:0]         n_char;

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        n_dig    = r_dig;
        n_strobe = 1'b0;
        n_last   = 1'b0;
        n_char   = r_char;
        if (r_active) begin
            n_strobe = 1'b1;
            n_idx    = r_idx + IW'(1);
            if (r_idx == IW'(NCHAR - 1)) begin
                n_char   = ASCII_NL;
                n_last   = 1'b1;
                n_active = 1'b0;
            end else if (r_idx == IW'(1)) begin
                n_char = ASCII_DOT;
            end else begin
                n_char = ASCII_ZERO + {4'd0, r_dig[0]};
                n_dig  = {4'd0, r_dig[ND-1:1]};
            end
        end
        if (r_val[ND]) begin
            n_active = 1'b1;
            n_idx    = '0;
            n_dig    = r_d[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
        r_idx  <= n_idx;
        r_dig  <= n_dig;
        r_char <= n_char;
    end

    assign o_strobe    = r_strobe;
    assign o_last      = r_last;
    assign o_character = r_char;

endmodule

`default_nettype wire

### rtl/core/acav_checker.sv
// acav_checker: port-level assertions for adc_code_to_ascii_voltage
// depends on acav_pkg; attached to the top level by the bind at the end of this file
`default_nettype none

module acav_checker import acav_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic [7:0] o_character,
    input wire logic       o_last
);

    // last only on a strobed newline
    a_last_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_strobe && o_character == ASCII_NL))
        else $error("last without strobed newline");

    // a transaction holds off the next one
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transaction");

    // the integer digit is followed by the decimal point
    a_dot_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |=> (o_strobe && o_character == ASCII_DOT))
        else $error("decimal point not second");

    // a reading closes with last before the strobe drops
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_strobe) |-> $past(o_last))
        else $error("strobe dropped without last");

endmodule

bind adc_code_to_ascii_voltage acav_checker u_acav_checker (.*);

`default_nettype wire

### dv/tb_adc_code_to_ascii_voltage.sv
// tb_adc_code_to_ascii_voltage: directed and random codes, each checked against ten expected chars
// depends on acav_pkg and adc_code_to_ascii_voltage; self-contained, no files or plusargs
`timescale 1ns / 100ps

module tb_adc_code_to_ascii_voltage;
    import acav_pkg::*;

    localparam int NUM_RANDOM    = 392;
    localparam int DRAIN_AT      = 200;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int TAIL_CYCLES   = 30;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ascii_char_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic [7:0] i_adc_code;
    logic       busy;
    logic       o_strobe;
    logic [7:0] o_character;
    logic       o_last;

    logic [7:0]  pending_codes[$];
    ascii_char_t expected_chars[$];
    ascii_char_t got_char;

    int n_sent;
    int gap_left;
    int err_count;
    int quiet_cycles;
    bit idle_ok;

    adc_code_to_ascii_voltage dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_adc_code  (i_adc_code),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // reading = floor(code * 5 * 10^digits / 255), sent as d.ddddddd\n
    function automatic void push_reading_chars(input logic [7:0] code);
        longint unsigned scale;
        longint unsigned reading;
        longint unsigned whole;
        longint unsigned frac;
        logic [7:0]      digs[FRACTION_DIGITS_DEF];
        scale = 1;
        for (int i = 0; i < FRACTION_DIGITS_DEF; i++) begin
            scale = scale * 10;
        end
        reading = (longint'(code) * longint'(FULL_SCALE_VOLTS) * scale)
                  / longint'(FULL_SCALE_CODE);
        whole = reading / scale;
        frac  = reading % scale;
        for (int i = FRACTION_DIGITS_DEF - 1; i >= 0; i--) begin
            digs[i] = 8'(frac % 10);
            frac    = frac / 10;
        end
        expected_chars.push_back('{ASCII_ZERO + 8'(whole % 10), 1'b0});
        expected_chars.push_back('{ASCII_DOT, 1'b0});
        for (int i = 0; i < FRACTION_DIGITS_DEF; i++) begin
            expected_chars.push_back('{ASCII_ZERO + digs[i], 1'b0});
        end
        expected_chars.push_back('{ASCII_NL, 1'b1});
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                push_reading_chars(i_adc_code);
                n_sent++;
            end
            idle_ok = pending_codes.size() > 50 && !(n_sent >= 100 && n_sent < 160);
            if (start && busy) begin
                // transaction held until accepted
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (n_sent == DRAIN_AT && expected_chars.size() != 0) begin
                start <= 1'b0;
            end else if (pending_codes.size() == 0) begin
                start <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(1, 18) - 1;
                start <= 1'b0;
            end else begin
                i_adc_code <= pending_codes.pop_front();
                start      <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected char: character %h last %b", o_character, o_last);
                err_count++;
            end else begin
                got_char = expected_chars.pop_front();
                if (o_character !== got_char.ch) begin
                    $error("character: expected %h, got %h", got_char.ch, o_character);
                    err_count++;
                end
                if (o_last !== got_char.last) begin
                    $error("last: expected %b, got %b", got_char.last, o_last);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("** adc_code_to_ascii_voltage: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_adc_code   = 8'd0;
        n_sent       = 0;
        gap_left     = 0;
        err_count    = 0;
        quiet_cycles = 0;

        // extremes, exact volt steps, midscale, alternating bit and nibble patterns
        pending_codes = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd51, 8'd102, 8'd153, 8'd204,
                          8'd128, 8'd127, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'd2, 8'd253,
                          8'd3, 8'd252};
        for (int i = 0; i < NUM_RANDOM; i++) begin
            pending_codes.push_back(8'($urandom_range(0, 255)));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_codes.size() != 0 || start) @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("** adc_code_to_ascii_voltage: PASSED **");
        end else begin
            $display("** adc_code_to_ascii_voltage: FAILED **");
        end
        $finish;
    end

endmodule
